### hw/rtl/rbp_pkg.sv
// Shared types and constants of the reference-counted buffer pool.
package rbp_pkg;

   localparam int NUM_BUFS = 64;
   localparam int IDX_W    = 6;
   localparam int SIZE_W   = 7;
   localparam int CNT_W    = 16;
   localparam int OCC_W    = 7;
   localparam int STAT_W   = 3;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [1:0] {
      CMD_CLAIM_FREE = 2'd0,
      CMD_CLAIM_HELD = 2'd1,
      CMD_RELEASE    = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_RANGE     = 3'd2,
      ST_NOT_HELD  = 3'd3,
      ST_SATURATED = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [IDX_W-1:0] buffer_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  granted_index;
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  usage_count;
      logic [OCC_W-1:0]  free_count;
   } rsp_type;

   // Effective pool size: the register value limited to the storage depth.
   function automatic logic [OCC_W-1:0] pool_size(input logic [SIZE_W-1:0] size);
      logic [OCC_W-1:0] n;
      n = (size > SIZE_W'(NUM_BUFS)) ? OCC_W'(NUM_BUFS) : OCC_W'(size);
      return n;
   endfunction

endpackage

### hw/rtl/rbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### hw/rtl/refcounted_buffer_pool_core.sv
// Reference-counted buffer pool: usage counts and free-index FIFO held in RAM.
//
// Request channel: start with req_data (cmd, buffer_index); a request is taken
// at a clock edge with start high and busy low. Commands: claim a free buffer
// (pop the oldest free index, count set to one), claim a held buffer (count
// plus one, saturating), release (count minus one, index pushed back to the
// free FIFO when it reaches zero).
// Result channel: rsp_valid strobes for one cycle with rsp_data; there is no
// back-pressure, the receiver must take it in that cycle.
// Pipeline: a request is registered into s1_req_ff, its result onto rsp_data.
// Throughput: one request per cycle while busy is low. Each request reads the
// count and FIFO RAMs when accepted and writes them back from s1; a one-entry
// bypass per RAM covers a request that reads what its predecessor writes.
// Configuration: csr_data written with csr_valid/csr_ready sets the pool size
// and reinitialises the pool (per-entry valid bits are cleared, so no clearing
// pass is needed). busy is high only during that write, and csr_ready is low
// while a request is in s1.
// Reset: synchronous; the pool comes up with 64 buffers, all free in order.
module refcounted_buffer_pool_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  rbp_pkg::req_type            req_data,
   output logic                        rsp_valid,
   output rbp_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rbp_pkg::SIZE_W-1:0]  csr_data
);
   import rbp_pkg::*;

   // control
   logic                 accept;
   logic                 csr_wr;
   logic                 s1_valid_ff;
   req_type              s1_req_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic [NUM_BUFS-1:0]  cnt_vld_ff;
   logic [NUM_BUFS-1:0]  fifo_vld_ff;

   // bypass of the last write to each RAM
   logic                 cw_vld_ff;
   logic [IDX_W-1:0]     cw_addr_ff;
   logic [CNT_W-1:0]     cw_data_ff;
   logic                 fw_vld_ff;
   logic [IDX_W-1:0]     fw_addr_ff;
   logic [IDX_W-1:0]     fw_data_ff;

   // RAM ports
   logic                 cnt_we;
   logic [IDX_W-1:0]     cnt_waddr;
   logic [CNT_W-1:0]     cnt_wdata;
   logic [CNT_W-1:0]     cnt_rdata;
   logic                 fifo_we;
   logic [IDX_W-1:0]     fifo_waddr;
   logic [IDX_W-1:0]     fifo_wdata;
   logic [IDX_W-1:0]     fifo_rdata;

   // datapath of the request stage
   logic [IDX_W-1:0]     idx;
   logic [OCC_W-1:0]     pool_n;
   logic                 in_range;
   logic [CNT_W-1:0]     cnt_cur;
   logic [IDX_W-1:0]     fifo_cur;
   logic                 pop;
   rsp_type              rsp_in;
   rsp_type              rsp_data_ff;
   logic                 rsp_valid_ff;

   logic [OCC_W-1:0]     init_n;

   assign csr_ready = ~s1_valid_ff;
   assign csr_wr    = csr_valid & csr_ready;
   assign busy      = csr_wr;
   assign accept    = start & ~busy;

   assign idx      = s1_req_ff.buffer_index;
   assign pool_n   = pool_size(size_ff);
   assign in_range = {1'b0, idx} < pool_n;
   assign init_n   = pool_size(csr_data);

   // Entries never written since init read as their reset values.
   assign cnt_cur  = (cw_vld_ff && cw_addr_ff == idx) ? cw_data_ff :
                     (cnt_vld_ff[idx] ? cnt_rdata : '0);
   assign fifo_cur = (fw_vld_ff && fw_addr_ff == head_ff) ? fw_data_ff :
                     (fifo_vld_ff[head_ff] ? fifo_rdata : head_ff);

   always_comb begin
      rsp_in.granted_index = idx;
      rsp_in.status        = ST_OK;
      rsp_in.usage_count   = '0;
      cnt_we     = 1'b0;
      cnt_waddr  = idx;
      cnt_wdata  = '0;
      fifo_we    = 1'b0;
      fifo_waddr = tail_ff;
      fifo_wdata = idx;
      pop        = 1'b0;
      head_in    = head_ff;
      tail_in    = tail_ff;
      occ_in     = occ_ff;
      if (s1_valid_ff) begin
         unique case (s1_req_ff.cmd)
            CMD_CLAIM_FREE: begin
               if (occ_ff == '0) begin
                  rsp_in.granted_index = '0;
                  rsp_in.status        = ST_EMPTY;
               end else begin
                  pop                  = 1'b1;
                  rsp_in.granted_index = fifo_cur;
                  rsp_in.usage_count   = CNT_W'(1);
                  cnt_we    = 1'b1;
                  cnt_waddr = fifo_cur;
                  cnt_wdata = CNT_W'(1);
                  head_in   = head_ff + IDX_W'(1);   // depth is a power of two
                  occ_in    = occ_ff - OCC_W'(1);
               end
            end
            CMD_CLAIM_HELD: begin
               if (!in_range) begin
                  rsp_in.status = ST_RANGE;
               end else if (cnt_cur == '0) begin
                  rsp_in.status = ST_NOT_HELD;
               end else if (cnt_cur == CNT_MAX) begin
                  rsp_in.status      = ST_SATURATED;
                  rsp_in.usage_count = cnt_cur;
               end else begin
                  rsp_in.usage_count = cnt_cur + CNT_W'(1);
                  cnt_we    = 1'b1;
                  cnt_wdata = cnt_cur + CNT_W'(1);
               end
            end
            CMD_RELEASE: begin
               if (!in_range) begin
                  rsp_in.status = ST_RANGE;
               end else if (cnt_cur != '0) begin
                  rsp_in.usage_count = cnt_cur - CNT_W'(1);
                  cnt_we    = 1'b1;
                  cnt_wdata = cnt_cur - CNT_W'(1);
                  if (cnt_cur == CNT_W'(1) && occ_ff < OCC_W'(NUM_BUFS)) begin
                     fifo_we = 1'b1;
                     tail_in = tail_ff + IDX_W'(1);
                     occ_in  = occ_ff + OCC_W'(1);
                  end
               end
            end
            default: begin
               // no operation: report the addressed count
               if (in_range) begin
                  rsp_in.usage_count = cnt_cur;
               end
            end
         endcase
      end
      rsp_in.free_count = occ_in;
   end

   rbp_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BUFS)) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (req_data.buffer_index),
      .rdata (cnt_rdata)
   );

   // read at the head the next request will see
   rbp_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BUFS)) u_fifo_ram (
      .clock (clock),
      .we    (fifo_we),
      .waddr (fifo_waddr),
      .wdata (fifo_wdata),
      .raddr (head_in),
      .rdata (fifo_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         size_ff      <= SIZE_W'(NUM_BUFS);
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= OCC_W'(NUM_BUFS);
         cnt_vld_ff   <= '0;
         fifo_vld_ff  <= '0;
         cw_vld_ff    <= 1'b0;
         fw_vld_ff    <= 1'b0;
      end else if (csr_wr) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         size_ff      <= csr_data;
         head_ff      <= '0;
         tail_ff      <= (init_n >= OCC_W'(NUM_BUFS)) ? '0 : init_n[IDX_W-1:0];
         occ_ff       <= init_n;
         cnt_vld_ff   <= '0;
         fifo_vld_ff  <= '0;
         cw_vld_ff    <= 1'b0;
         fw_vld_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         rsp_valid_ff <= s1_valid_ff;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         cw_vld_ff    <= cnt_we;
         fw_vld_ff    <= fifo_we;
         if (cnt_we) begin
            cnt_vld_ff[cnt_waddr] <= 1'b1;
         end
         if (fifo_we) begin
            fifo_vld_ff[fifo_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
      end
      rsp_data_ff <= rsp_in;
      cw_addr_ff  <= cnt_waddr;
      cw_data_ff  <= cnt_wdata;
      fw_addr_ff  <= fifo_waddr;
      fw_data_ff  <= fifo_wdata;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(NUM_BUFS))
      else $error("free FIFO occupancy beyond pool depth");

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(s1_valid_ff))
      else $error("result strobe without a request in flight");

   a_no_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(pop && fifo_we))
      else $error("push and pop of the free FIFO in one cycle");

   a_grant_count: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && pop) |=> (rsp_data.usage_count == CNT_W'(1)
                                && rsp_data.status == ST_OK))
      else $error("claim of a free buffer did not report a count of one");

endmodule

### tb/tb_refcounted_buffer_pool_core.sv
// Self-checking testbench for the reference-counted buffer pool core.
`timescale 1ns / 100ps

module tb_refcounted_buffer_pool_core;
   import rbp_pkg::*;

   localparam logic [1:0] CMD_NOP     = 2'd3;   // undefined command, no state change
   localparam int         CYCLE_LIMIT = 600000;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [SIZE_W-1:0]   csr_data;

   // pool state as the checker expects it
   logic [CNT_W-1:0]    held_count [NUM_BUFS];
   logic [IDX_W-1:0]    free_ring  [NUM_BUFS];
   logic [IDX_W-1:0]    ring_head;
   logic [IDX_W-1:0]    ring_tail;
   logic [OCC_W-1:0]    ring_fill;
   logic [SIZE_W-1:0]   pool_size_reg;

   req_type             cmd_backlog [$];
   rsp_type             awaited_rsp [$];

   int                  idle_pct;
   bit                  draining;
   int                  mismatch_count;
   int                  reqs_taken;
   int                  rsps_checked;
   int                  size_writes;
   int                  status_tally [5];
   int                  cycle_count;

   refcounted_buffer_pool_core DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic logic [OCC_W-1:0] live_buffers();
      return (pool_size_reg > SIZE_W'(NUM_BUFS)) ? OCC_W'(NUM_BUFS) : OCC_W'(pool_size_reg);
   endfunction

   // size write: every buffer free, free ring back to 0..n-1 in order
   function automatic void reload_pool(input logic [SIZE_W-1:0] size);
      logic [OCC_W-1:0] n;
      pool_size_reg = size;
      n = live_buffers();
      for (int i = 0; i < NUM_BUFS; i++) begin
         held_count[i] = '0;
         free_ring[i]  = IDX_W'(i);
      end
      ring_head = '0;
      ring_fill = n;
      ring_tail = IDX_W'(n);   // wraps to 0 for a full pool
   endfunction

   function automatic rsp_type pool_outcome(input req_type r);
      rsp_type          o;
      logic [OCC_W-1:0] n;
      logic [CNT_W-1:0] c;
      n = live_buffers();
      c = held_count[r.buffer_index];
      o.granted_index = r.buffer_index;
      o.status        = ST_OK;
      o.usage_count   = '0;
      case (r.cmd)
         CMD_CLAIM_FREE: begin
            if (ring_fill == 0) begin
               o.granted_index = '0;
               o.status        = ST_EMPTY;
            end else begin
               o.granted_index = free_ring[ring_head];
               ring_head++;
               ring_fill--;
               held_count[o.granted_index] = CNT_W'(1);
               o.usage_count = CNT_W'(1);
            end
         end
         CMD_CLAIM_HELD: begin
            if (OCC_W'(r.buffer_index) >= n) begin
               o.status = ST_RANGE;
            end else if (c == 0) begin
               o.status = ST_NOT_HELD;
            end else if (c == CNT_MAX) begin
               o.status      = ST_SATURATED;
               o.usage_count = c;
            end else begin
               held_count[r.buffer_index] = c + 1'b1;
               o.usage_count = c + 1'b1;
            end
         end
         CMD_RELEASE: begin
            if (OCC_W'(r.buffer_index) >= n) begin
               o.status = ST_RANGE;
            end else if (c != 0) begin
               // releasing a free buffer is silently ok
               held_count[r.buffer_index] = c - 1'b1;
               o.usage_count = c - 1'b1;
               if (c == 1 && ring_fill < OCC_W'(NUM_BUFS)) begin
                  free_ring[ring_tail] = r.buffer_index;
                  ring_tail++;
                  ring_fill++;
               end
            end
         end
         default: begin
            if (OCC_W'(r.buffer_index) < n) o.usage_count = c;
         end
      endcase
      o.free_count = ring_fill;
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $time, msg);
   endtask

   // request driver
   always @(posedge clock) begin : drive_proc
      bit took;
      if (reset) begin
         start <= 1'b0;
      end else begin
         took = start && !busy;
         if (took) begin
            awaited_rsp.push_back(pool_outcome(req_data));
            reqs_taken++;
         end
         if (draining && awaited_rsp.size() == 0) draining = 1'b0;
         if (start && !took) begin
            // held by busy: keep the request up
         end else if (cmd_backlog.size() != 0 && !draining &&
                      $urandom_range(99) >= idle_pct) begin
            start    <= 1'b1;
            req_data <= cmd_backlog.pop_front();
            if ($urandom_range(149) == 0) draining = 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : check_proc
      rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            reload_pool(csr_data);
            size_writes++;
         end
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               want = awaited_rsp.pop_front();
               rsps_checked++;
               if (want.status < 5) status_tally[want.status]++;
               if (rsp_data.granted_index !== want.granted_index)
                  report_mismatch($sformatf("granted_index %0d, expected %0d",
                                            rsp_data.granted_index, want.granted_index));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.usage_count !== want.usage_count)
                  report_mismatch($sformatf("usage_count %0d, expected %0d",
                                            rsp_data.usage_count, want.usage_count));
               if (rsp_data.free_count !== want.free_count)
                  report_mismatch($sformatf("free_count %0d, expected %0d",
                                            rsp_data.free_count, want.free_count));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic queue_cmd(input logic [1:0] c, input logic [IDX_W-1:0] i);
      req_type r;
      r.cmd          = c;
      r.buffer_index = i;
      cmd_backlog.push_back(r);
   endtask

   // mostly in-range traffic so buffers get claimed, shared and freed again
   task automatic queue_random(input int count, input int n);
      int pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 30)
            queue_cmd(CMD_CLAIM_FREE, IDX_W'($urandom_range(NUM_BUFS - 1)));
         else if (pick < 55)
            queue_cmd(CMD_CLAIM_HELD, IDX_W'($urandom_range(n - 1)));
         else if (pick < 90)
            queue_cmd(CMD_RELEASE, IDX_W'($urandom_range(n - 1)));
         else
            queue_cmd(2'($urandom_range(3)), IDX_W'($urandom_range(NUM_BUFS - 1)));
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (cmd_backlog.size() != 0 || start || awaited_rsp.size() != 0);
      repeat (4) @(posedge clock);   // margin for the pipeline to empty
   endtask

   task automatic write_pool_size(input logic [SIZE_W-1:0] v);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [SIZE_W-1:0] seg_size [6];
      int                n;
      seg_size = '{7'd8, 7'd64, 7'd4, 7'd127, 7'd16, 7'd2};
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      csr_valid      = 1'b0;
      csr_data       = '0;
      idle_pct       = 23;
      draining       = 1'b0;
      mismatch_count = 0;
      reqs_taken     = 0;
      rsps_checked   = 0;
      size_writes    = 0;
      cycle_count    = 0;
      status_tally   = '{default: 0};
      reload_pool(SIZE_W'(NUM_BUFS));
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // full pool after reset
      queue_cmd(CMD_CLAIM_FREE, 6'd63);
      queue_cmd(CMD_CLAIM_HELD, 6'd0);
      queue_cmd(CMD_CLAIM_HELD, 6'd63);
      queue_cmd(CMD_RELEASE,    6'd0);
      queue_cmd(CMD_RELEASE,    6'd0);
      queue_cmd(CMD_RELEASE,    6'd0);
      queue_cmd(CMD_NOP,        6'd0);
      queue_cmd(CMD_NOP,        6'd63);
      queue_cmd(CMD_CLAIM_FREE, 6'd0);
      wait_idle();
      // single buffer: empty pool and out-of-range indices
      write_pool_size(7'd1);
      queue_cmd(CMD_CLAIM_FREE, 6'd0);
      queue_cmd(CMD_CLAIM_FREE, 6'd0);
      queue_cmd(CMD_CLAIM_HELD, 6'd1);
      queue_cmd(CMD_RELEASE,    6'd63);
      queue_cmd(CMD_RELEASE,    6'd0);
      queue_cmd(CMD_NOP,        6'd63);
      wait_idle();
      // zero-size pool
      write_pool_size(7'd0);
      queue_cmd(CMD_CLAIM_FREE, 6'd0);
      queue_cmd(CMD_CLAIM_HELD, 6'd0);
      queue_cmd(CMD_RELEASE,    6'd0);
      wait_idle();
      // oversize register value, clipped to the storage depth
      write_pool_size(7'd127);
      queue_cmd(CMD_CLAIM_FREE, 6'd5);
      queue_cmd(CMD_CLAIM_HELD, 6'd63);
      queue_cmd(CMD_RELEASE,    6'd63);
      queue_cmd(CMD_NOP,        6'd63);
      wait_idle();

      for (int s = 0; s < 6; s++) begin
         idle_pct = (s < 2) ? 23 : (s < 4) ? 77 : 0;
         write_pool_size(seg_size[s]);
         n = (seg_size[s] > SIZE_W'(NUM_BUFS)) ? NUM_BUFS : int'(seg_size[s]);
         queue_random(335, n);
         wait_idle();
      end

      if (awaited_rsp.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", awaited_rsp.size()));
      $display("Run covered %0d requests over %0d pool size writes, %0d results checked",
               reqs_taken, size_writes, rsps_checked);
      $display("Status mix: ok %0d, empty %0d, range %0d, not held %0d, saturated %0d",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3],
               status_tally[4]);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
